// ===== src/chce_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the canonical Huffman encoder.
// Depends on nothing; every other file imports it.
package chce_pkg;

   // Sizes of the code table and the fields
   localparam int SYMBOL_COUNT = 256;
   localparam int MAX_CODE_LEN = 16;
   localparam int SYM_W        = 8;
   localparam int LEN_W        = 5;
   localparam int BYTE_W       = 8;
   localparam int CODE_W       = MAX_CODE_LEN;
   localparam int NEXT_W       = CODE_W + 1;
   localparam int MAP_W        = LEN_W + CODE_W;
   localparam int MAP_AW       = $clog2(SYMBOL_COUNT);
   localparam int CNT_W        = $clog2(SYMBOL_COUNT + 1);
   localparam int REM_W        = $clog2(BYTE_W);
   localparam int PACK_W       = MAX_CODE_LEN + BYTE_W - 1;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_ENCODE = 2'd2,
      CMD_FLUSH  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_SYMBOL  = 2'd1,
      ST_BAD_LENGTH = 2'd2,
      ST_TABLE_FULL = 2'd3
   } status_type;

   // Item in the execute stage, seen by the table and the packer
   typedef struct packed {
      logic                 fire;
      cmd_type              cmd;
      logic [SYM_W-1:0]     symbol;
      logic [LEN_W-1:0]     code_length;
   } table_op_type;

   // Code table answer for the symbol in the execute stage
   typedef struct packed {
      logic                 hit;
      logic [LEN_W-1:0]     len;
      logic [CODE_W-1:0]    code;
   } lookup_type;

   // One result word
   typedef struct packed {
      logic [BYTE_W-1:0]    out_byte;
      logic                 byte_valid;
      logic                 last;
      status_type           status;
   } result_type;

endpackage

// ===== src/canonical_huffman_encoder.sv =====
`timescale 1ns / 1ps
// Top level of the canonical Huffman encoder: input stage, code table,
// bit packer and result buffer. Uses chce_pkg and the chce_* modules.
//
//   channel  direction  handshake               word
//   req      in         req_valid / req_stall   cmd, symbol, code_length
//   rsp      out        rsp_valid / rsp_stall   out_byte, byte_valid, last, status
//
// A word is taken into the input stage (which also reads the code table),
// executes once the result buffer has room, and its results are registered in
// the result buffer and appear in the cycle after. An encode that completes two
// bytes hands them out one at a time on the single-word rsp channel.
// Reset clears the table valid bits, the code counter and the bit buffer.
// rsp_stall holds the result buffer and then back-pressures req via req_stall.
module canonical_huffman_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [chce_pkg::SYM_W-1:0]    req_symbol,
   input  logic [chce_pkg::LEN_W-1:0]    req_code_length,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [chce_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last,
   output logic [1:0]                    rsp_status
);
   import chce_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff;
   logic [SYM_W-1:0]  s1_sym_ff;
   logic [LEN_W-1:0]  s1_len_ff;
   logic              accept, fire, space, two;
   table_op_type      op;
   status_type        add_status;
   lookup_type        lookup;
   result_type        res0, res1, head;

   // Input stage handshake
   assign fire      = s1_valid_ff && space;
   assign req_stall = s1_valid_ff && !space;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= cmd_type'(req_cmd);
         s1_sym_ff <= req_symbol;
         s1_len_ff <= req_code_length;
      end
   end

   assign op = '{fire: fire, cmd: s1_cmd_ff, symbol: s1_sym_ff, code_length: s1_len_ff};

   chce_code_table u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_symbol  (req_symbol),
      .op         (op),
      .add_status (add_status),
      .lookup     (lookup)
   );

   chce_bit_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .add_status (add_status),
      .lookup     (lookup),
      .res0       (res0),
      .res1       (res1),
      .two        (two)
   );

   chce_out_buffer u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .push_two   (two),
      .res0       (res0),
      .res1       (res1),
      .space      (space),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .head       (head)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_byte_valid = head.byte_valid;
   assign rsp_last       = head.last;
   assign rsp_status     = head.status;

endmodule

// ===== src/chce_code_table.sv =====
`timescale 1ns / 1ps
// Code table: per-symbol length/code memory with valid flops, and the
// canonical code counter that assigns codes as entries are added. Uses chce_pkg.
module chce_code_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [chce_pkg::SYM_W-1:0]  rd_symbol,
   input  chce_pkg::table_op_type      op,
   output chce_pkg::status_type        add_status,
   output chce_pkg::lookup_type        lookup
);
   import chce_pkg::*;

   logic [MAP_W-1:0]        map_mem [SYMBOL_COUNT];
   logic [MAP_W-1:0]        rd_data_ff;
   logic [SYMBOL_COUNT-1:0] valid_ff, valid_in;
   logic [NEXT_W-1:0]       next_code_ff, next_code_in;
   logic [LEN_W-1:0]        cur_len_ff, cur_len_in;
   logic [CNT_W-1:0]        entry_count_ff, entry_count_in;
   logic                    sym_in_range;
   logic [MAP_AW-1:0]       op_idx, rd_idx;
   logic [LEN_W-1:0]        shift_amt;
   logic [NEXT_W-1:0]       adv_code;
   logic                    code_overflow;
   logic                    wr_en;
   logic [MAP_W-1:0]        wr_data;

   assign sym_in_range = {1'b0, op.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
   assign op_idx       = op.symbol[MAP_AW-1:0];
   assign rd_idx       = rd_symbol[MAP_AW-1:0];

   // Advance the counter to the new length: one doubling per extra bit
   assign shift_amt     = op.code_length - cur_len_ff;
   assign adv_code      = next_code_ff << shift_amt;
   assign code_overflow = (adv_code >> op.code_length) != '0;
   assign wr_data       = {op.code_length, adv_code[CODE_W-1:0]};

   // Clear and add handling
   always_comb begin
      add_status     = ST_OK;
      wr_en          = 1'b0;
      valid_in       = valid_ff;
      next_code_in   = next_code_ff;
      cur_len_in     = cur_len_ff;
      entry_count_in = entry_count_ff;
      if (op.fire) begin
         case (op.cmd)
            CMD_CLEAR: begin
               valid_in       = '0;
               next_code_in   = '0;
               cur_len_in     = LEN_W'(1);
               entry_count_in = '0;
            end
            CMD_ADD: begin
               if (op.code_length == '0 || op.code_length > LEN_W'(MAX_CODE_LEN) ||
                   op.code_length < cur_len_ff) begin
                  add_status = ST_BAD_LENGTH;
               end else if (entry_count_ff >= CNT_W'(SYMBOL_COUNT) || !sym_in_range) begin
                  add_status = ST_TABLE_FULL;
               end else if (code_overflow) begin
                  add_status = ST_BAD_LENGTH;
               end else begin
                  // first mapping of a symbol wins; duplicates still take a code
                  if (!valid_ff[op_idx]) begin
                     wr_en            = 1'b1;
                     valid_in[op_idx] = 1'b1;
                  end
                  next_code_in   = adv_code + 1'b1;
                  cur_len_in     = op.code_length;
                  entry_count_in = entry_count_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         next_code_ff   <= '0;
         cur_len_ff     <= LEN_W'(1);
         entry_count_ff <= '0;
      end else begin
         valid_ff       <= valid_in;
         next_code_ff   <= next_code_in;
         cur_len_ff     <= cur_len_in;
         entry_count_ff <= entry_count_in;
      end
   end

   // Table memory; a write in the same cycle as a read of that entry bypasses
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[op_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= (wr_en && op_idx == rd_idx) ? wr_data : map_mem[rd_idx];
      end
   end

   assign lookup.hit  = sym_in_range && valid_ff[op_idx];
   assign lookup.len  = rd_data_ff[MAP_W-1:CODE_W];
   assign lookup.code = rd_data_ff[CODE_W-1:0];

endmodule

// ===== src/chce_bit_packer.sv =====
`timescale 1ns / 1ps
// Bit packer: appends codes MSB first, cuts full bytes, pads on flush,
// and forms the result words of every command. Uses chce_pkg.
module chce_bit_packer (
   input  logic                    clock,
   input  logic                    reset,
   input  chce_pkg::table_op_type  op,
   input  chce_pkg::status_type    add_status,
   input  chce_pkg::lookup_type    lookup,
   output chce_pkg::result_type    res0,
   output chce_pkg::result_type    res1,
   output logic                    two
);
   import chce_pkg::*;

   // Leftover bits, always fewer than a byte
   logic [BYTE_W-2:0] bits_ff, bits_in;
   logic [REM_W-1:0]  cnt_ff, cnt_in;
   logic [PACK_W-1:0] pack_word;
   logic [LEN_W-1:0]  total;
   logic [BYTE_W-1:0] byte_a, byte_b, flush_byte;
   logic [BYTE_W-2:0] keep_mask;

   assign pack_word  = (PACK_W'(bits_ff) << lookup.len) | PACK_W'(lookup.code);
   assign total      = LEN_W'(cnt_ff) + lookup.len;
   assign byte_a     = BYTE_W'(pack_word >> (total - LEN_W'(BYTE_W)));
   assign byte_b     = BYTE_W'(pack_word >> (total - LEN_W'(2 * BYTE_W)));
   assign flush_byte = {1'b0, bits_ff} << ((REM_W + 1)'(BYTE_W) - {1'b0, cnt_ff});

   always_comb begin
      res0      = '{out_byte: '0, byte_valid: 1'b0, last: 1'b1, status: ST_OK};
      res1      = res0;
      two       = 1'b0;
      cnt_in    = cnt_ff;
      bits_in   = bits_ff;
      keep_mask = '0;
      case (op.cmd)
         CMD_ADD: begin
            res0.status = add_status;
         end
         CMD_ENCODE: begin
            if (!lookup.hit) begin
               res0.status = ST_NO_SYMBOL;
            end else begin
               if (total >= LEN_W'(2 * BYTE_W)) begin
                  res0   = '{out_byte: byte_a, byte_valid: 1'b1, last: 1'b0, status: ST_OK};
                  res1   = '{out_byte: byte_b, byte_valid: 1'b1, last: 1'b1, status: ST_OK};
                  two    = 1'b1;
                  cnt_in = REM_W'(total - LEN_W'(2 * BYTE_W));
               end else if (total >= LEN_W'(BYTE_W)) begin
                  res0   = '{out_byte: byte_a, byte_valid: 1'b1, last: 1'b1, status: ST_OK};
                  cnt_in = REM_W'(total - LEN_W'(BYTE_W));
               end else begin
                  cnt_in = REM_W'(total);
               end
               // keep only the bits not yet emitted
               keep_mask = ~({(BYTE_W - 1){1'b1}} << cnt_in);
               bits_in   = pack_word[BYTE_W-2:0] & keep_mask;
            end
         end
         CMD_FLUSH: begin
            if (cnt_ff != '0) begin
               res0 = '{out_byte: flush_byte, byte_valid: 1'b1, last: 1'b1, status: ST_OK};
            end
            cnt_in  = '0;
            bits_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         cnt_ff  <= '0;
      end else if (op.fire) begin
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== src/chce_out_buffer.sv =====
`timescale 1ns / 1ps
// Two-entry result buffer between the execute stage and the rsp channel.
// Uses chce_pkg.
module chce_out_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  push_two,
   input  chce_pkg::result_type  res0,
   input  chce_pkg::result_type  res1,
   output logic                  space,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output chce_pkg::result_type  head
);
   import chce_pkg::*;

   result_type slot0_ff, slot1_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = count_ff != 2'd0;
   assign pop       = rsp_valid && !rsp_stall;
   // room for two words once this cycle's pop is done
   assign space     = count_ff == 2'd0 || (count_ff == 2'd1 && !rsp_stall);
   assign head      = slot0_ff;

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = push_two ? 2'd2 : 2'd1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot0_ff <= res0;
         slot1_ff <= res1;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

endmodule

// ===== dv/tb_canonical_huffman_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for canonical_huffman_encoder: directed table, encode
// and flush tests, a back-pressure test and random traffic, all checked word by
// word against an in-bench model. Depends on chce_pkg and the encoder RTL.
module tb_canonical_huffman_encoder;
   import chce_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 170;
   localparam int DRAIN_CYCLES = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_cmd = CMD_CLEAR;
   logic [SYM_W-1:0]    req_symbol = '0;
   logic [LEN_W-1:0]    req_code_length = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_last;
   logic [1:0]          rsp_status;

   // Model state: code table, code counter and bit packer
   logic                map_valid [SYMBOL_COUNT];
   logic [LEN_W-1:0]    map_len   [SYMBOL_COUNT];
   logic [CODE_W-1:0]   map_code  [SYMBOL_COUNT];
   logic [NEXT_W-1:0]   code_counter;
   logic [LEN_W-1:0]    code_len_now;
   logic [CNT_W-1:0]    table_entries;
   logic [PACK_W-1:0]   pack_bits;
   logic [4:0]          pack_count;

   result_type          expected_words[$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  hold_request = 0;
   bit                  quiet_req = 1'b0;
   bit                  quiet_rsp = 1'b0;

   canonical_huffman_encoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_symbol      (req_symbol),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Idle length: mostly short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void push_result(logic [BYTE_W-1:0] b, logic v, logic l,
                                       status_type st);
      result_type r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.last       = l;
      r.status     = st;
      expected_words.push_back(r);
   endfunction

   // Canonical code assignment for one table entry
   function automatic status_type add_code(logic [SYM_W-1:0] sym,
                                           logic [LEN_W-1:0] len);
      logic [NEXT_W-1:0] code;
      logic [LEN_W-1:0]  clen;
      if (len < 1 || len > MAX_CODE_LEN || len < code_len_now) return ST_BAD_LENGTH;
      if (table_entries >= SYMBOL_COUNT || int'(sym) >= SYMBOL_COUNT)
         return ST_TABLE_FULL;
      code = code_counter;
      clen = code_len_now;
      while (clen < len) begin
         code = code << 1;
         clen++;
      end
      if (int'(code) >= (1 << len)) return ST_BAD_LENGTH;
      // duplicate symbol: slot consumed, first mapping kept
      if (!map_valid[sym]) begin
         map_valid[sym] = 1'b1;
         map_len[sym]   = len;
         map_code[sym]  = code[CODE_W-1:0];
      end
      code_counter  = code + 1'b1;
      code_len_now  = clen;
      table_entries = table_entries + 1'b1;
      return ST_OK;
   endfunction

   // Expected result words for one accepted request word
   function automatic void predict_words(cmd_type cmd, logic [SYM_W-1:0] sym,
                                         logic [LEN_W-1:0] len);
      result_type        emitted [2];
      int                n;
      logic [BYTE_W-1:0] packed_byte;
      n = 0;
      case (cmd)
         CMD_CLEAR: begin
            foreach (map_valid[i]) map_valid[i] = 1'b0;
            code_counter  = '0;
            code_len_now  = 1;
            table_entries = '0;
            push_result('0, 1'b0, 1'b1, ST_OK);
         end
         CMD_ADD: push_result('0, 1'b0, 1'b1, add_code(sym, len));
         CMD_ENCODE: begin
            if (int'(sym) >= SYMBOL_COUNT || !map_valid[sym]) begin
               push_result('0, 1'b0, 1'b1, ST_NO_SYMBOL);
            end else begin
               pack_bits  = (pack_bits << map_len[sym]) | PACK_W'(map_code[sym]);
               pack_count = pack_count + map_len[sym];
               while (pack_count >= 8 && n < 2) begin
                  packed_byte = BYTE_W'(pack_bits >> (pack_count - 5'd8));
                  pack_count  = pack_count - 5'd8;
                  pack_bits   = pack_bits & ((PACK_W'(1) << pack_count) - PACK_W'(1));
                  emitted[n].out_byte   = packed_byte;
                  emitted[n].byte_valid = 1'b1;
                  emitted[n].last       = 1'b0;
                  emitted[n].status     = ST_OK;
                  n++;
               end
               if (n == 0) begin
                  push_result('0, 1'b0, 1'b1, ST_OK);
               end else begin
                  emitted[n-1].last = 1'b1;
                  for (int i = 0; i < n; i++) expected_words.push_back(emitted[i]);
               end
            end
         end
         default: begin
            // flush only emits when bits remain
            if (pack_count > 0) begin
               packed_byte = BYTE_W'(pack_bits << (5'd8 - pack_count));
               pack_bits   = '0;
               pack_count  = '0;
               push_result(packed_byte, 1'b1, 1'b1, ST_OK);
            end else begin
               push_result('0, 1'b0, 1'b1, ST_OK);
            end
         end
      endcase
   endfunction

   // Offer one request word, predict at acceptance, then maybe idle
   task automatic send_word(cmd_type cmd, logic [SYM_W-1:0] sym,
                            logic [LEN_W-1:0] len);
      int gap;
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_symbol      <= sym;
      req_code_length <= len;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_words(cmd, sym, len);
      gap = 0;
      if (!quiet_req && $urandom_range(1) == 1) gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver stall pattern, with an optional long hold-off
   initial begin
      int run;
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            for (run = 0; run < hold_request; run++) @(posedge clock);
            hold_request = 0;
         end else if (quiet_rsp) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b1;
            run = idle_len();
            repeat (run) @(posedge clock);
         end
      end
   end

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_words.size() == 0) begin
            if (mismatch_count < 10)
               $display("[%0t] unexpected rsp word: byte %02h valid %0b last %0b status %0d",
                        $time, rsp_out_byte, rsp_byte_valid, rsp_last, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_byte_valid !== want.byte_valid ||
                rsp_last !== want.last || rsp_status !== want.status) begin
               if (mismatch_count < 10)
                  $display("[%0t] rsp mismatch: exp %02h/%0b/%0b/%0d got %02h/%0b/%0b/%0d",
                           $time, want.out_byte, want.byte_valid, want.last, want.status,
                           rsp_out_byte, rsp_byte_valid, rsp_last, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Empty table after reset, flush of an empty buffer
   task automatic test_reset_state();
      send_word(CMD_ENCODE, 8'h00, 5'd0);
      send_word(CMD_FLUSH, 8'hFF, 5'd31);
   endtask

   // Loading: length steps, duplicate, bad lengths
   task automatic test_table_load();
      send_word(CMD_CLEAR, 8'h00, 5'd0);
      send_word(CMD_ADD, 8'h00, 5'd1);
      send_word(CMD_ADD, 8'hFF, 5'd3);
      send_word(CMD_ADD, 8'hFF, 5'd3);   // duplicate: first code kept
      send_word(CMD_ADD, 8'h80, 5'd16);
      send_word(CMD_ADD, 8'h01, 5'd16);
      send_word(CMD_ADD, 8'h02, 5'd0);
      send_word(CMD_ADD, 8'h02, 5'd17);
      send_word(CMD_ADD, 8'h02, 5'd31);
      send_word(CMD_ADD, 8'h02, 5'd5);   // shorter than the current length
   endtask

   // Short and long codes, unknown symbol, two bytes from one word
   task automatic test_encode_bytes();
      send_word(CMD_ENCODE, 8'h00, 5'd0);
      send_word(CMD_ENCODE, 8'h80, 5'd0);
      send_word(CMD_ENCODE, 8'hFF, 5'd0);
      send_word(CMD_ENCODE, 8'h01, 5'd0);
      send_word(CMD_ENCODE, 8'h7E, 5'd0);
      send_word(CMD_FLUSH, 8'h00, 5'd0);
      send_word(CMD_FLUSH, 8'h00, 5'd0);
   endtask

   // Clear keeps pending bits; counter overflow within a length
   task automatic test_clear_and_overflow();
      send_word(CMD_ENCODE, 8'hFF, 5'd0);
      send_word(CMD_CLEAR, 8'h55, 5'd10);
      send_word(CMD_ENCODE, 8'hFF, 5'd0);
      send_word(CMD_FLUSH, 8'h00, 5'd0);
      send_word(CMD_ADD, 8'h10, 5'd1);
      send_word(CMD_ADD, 8'h11, 5'd1);
      send_word(CMD_ADD, 8'h12, 5'd1);
      send_word(CMD_ADD, 8'h12, 5'd2);
      send_word(CMD_ENCODE, 8'h11, 5'd0);
      send_word(CMD_FLUSH, 8'h00, 5'd0);
   endtask

   // Fill all 256 entries at length 8, then overfill
   task automatic test_table_full();
      send_word(CMD_CLEAR, 8'h00, 5'd0);
      for (int s = 0; s < SYMBOL_COUNT; s++) send_word(CMD_ADD, SYM_W'(s), 5'd8);
      send_word(CMD_ADD, 8'hA5, 5'd16);
      send_word(CMD_ADD, 8'h5A, 5'd8);
      send_word(CMD_ADD, 8'h5A, 5'd7);   // bad length wins over full
      send_word(CMD_ENCODE, 8'h00, 5'd0);
      send_word(CMD_ENCODE, 8'hFF, 5'd0);
   endtask

   // Long receiver hold-off while words keep coming
   task automatic test_backpressure();
      quiet_req = 1'b1;
      quiet_rsp = 1'b1;
      hold_request = 300;
      for (int i = 0; i < 40; i++) send_word(CMD_ENCODE, SYM_W'($urandom_range(255)), 5'd0);
      quiet_req = 1'b0;
      quiet_rsp = 1'b0;
   endtask

   // Random tables in DHT order, then mostly valid encodes, plus noise
   task automatic test_random_traffic();
      logic [SYM_W-1:0] loaded[$];
      int               sent;
      int               len;
      int               r;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         quiet_req = ($urandom_range(4) == 0);
         quiet_rsp = ($urandom_range(4) == 0);
         loaded.delete();
         send_word(CMD_CLEAR, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(31)));
         sent++;
         len = ($urandom_range(5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 5);
         repeat ($urandom_range(1, 24)) begin
            if ($urandom_range(19) == 0) begin
               send_word(CMD_ADD, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(31)));
            end else begin
               if ($urandom_range(1) == 1 && len < MAX_CODE_LEN) len++;
               loaded.push_back(SYM_W'($urandom_range(255)));
               send_word(CMD_ADD, loaded[$], LEN_W'(len));
            end
            sent++;
         end
         repeat ($urandom_range(10, 40)) begin
            r = $urandom_range(99);
            if (r < 80 && loaded.size() > 0)
               send_word(CMD_ENCODE, loaded[$urandom_range(loaded.size() - 1)],
                         LEN_W'($urandom_range(31)));
            else if (r < 88)
               send_word(CMD_FLUSH, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(31)));
            else if (r < 94)
               send_word(CMD_ENCODE, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(31)));
            else
               send_word(cmd_type'($urandom_range(3)), SYM_W'($urandom_range(255)),
                         LEN_W'($urandom_range(31)));
            sent++;
         end
      end
      quiet_req = 1'b0;
   endtask

   initial begin
      foreach (map_valid[i]) map_valid[i] = 1'b0;
      code_counter  = '0;
      code_len_now  = 1;
      table_entries = '0;
      pack_bits     = '0;
      pack_count    = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_table_load();
      test_encode_bytes();
      test_clear_and_overflow();
      test_table_full();
      test_backpressure();
      test_random_traffic();

      // drain, then give the block time to show any extra word
      req_valid <= 1'b0;
      quiet_rsp = 1'b1;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
src/chce_pkg.sv
src/chce_code_table.sv
src/chce_bit_packer.sv
src/chce_out_buffer.sv
src/canonical_huffman_encoder.sv
dv/tb_canonical_huffman_encoder.sv
